FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, clocked on clk with async reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mswc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswc_pkg
// shared types and constants for the markup-stripping word counter
// ----------------------------------------------------------------------------
package mswc_pkg;

	localparam int COUNT_WIDTH_DEF   = 32;
	localparam int ENTITY_LENGTH_DEF = 6;
	localparam int TOTAL_WIDTH       = 32;
	localparam int SKIP_WIDTH        = 3;

	localparam logic [7:0] CHAR_LT    = 8'h3C;
	localparam logic [7:0] CHAR_GT    = 8'h3E;
	localparam logic [7:0] CHAR_AMP   = 8'h26;
	localparam logic [7:0] CHAR_N     = 8'h6E;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_TAB   = 8'h09;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [TOTAL_WIDTH-1:0] word_total;
		logic                   total_saturated;
	} out_item_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CHAR_SPACE) || (b == CHAR_LF) || (b == CHAR_TAB);
	endfunction

endpackage

FILE: src/markup_stripping_word_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_stripping_word_counter
// strips tags and ENTITY_LENGTH-byte entities (six by default) from a byte stream and counts words
// ----------------------------------------------------------------------------
// One byte is taken per cycle, with no gaps needed between bytes. Each byte is
// registered, then decided against a lookahead window of ENTITY_LENGTH bytes
// in a single pass of logic; the count result is registered in the result
// register once the byte marked end_of_text leaves the input stage. Bytes before
// the last one keep flowing while a result waits; the next document starts
// right after the final byte, with all state back to its reset values. A stall
// of out_ready only holds the input when a final byte needs the result register.
`include "assert_macros.svh"

module markup_stripping_word_counter #(
	parameter int COUNT_WIDTH   = mswc_pkg::COUNT_WIDTH_DEF,
	parameter int ENTITY_LENGTH = mswc_pkg::ENTITY_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mswc_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mswc_pkg::out_item_t out_item
);

	localparam int L       = ENTITY_LENGTH;
	localparam int TALLY_W = (COUNT_WIDTH > 32) ? 32 : COUNT_WIDTH;
	localparam int FW      = $clog2(L + 1);
	localparam int SW      = mswc_pkg::SKIP_WIDTH;
	localparam logic [TALLY_W-1:0] LIMIT = {TALLY_W{1'b1}};

	// input stage
	logic               valid_s1;
	mswc_pkg::in_item_t item_s1;
	logic               adv_s1;

	// block state
	logic               inside_q;
	logic               prev_blank_q;
	logic [TALLY_W-1:0] tally_q;
	logic [SW-1:0]      skip_q;
	logic [7:0]         win_q [L];
	logic [FW-1:0]      fill_q;

	// result register
	logic                out_valid_q;
	mswc_pkg::out_item_t out_item_q;

	// single-pass decision logic
	logic [7:0]         ext [L];
	logic [FW-1:0]      ext_cnt;
	logic [FW-1:0]      nret;
	logic               inside_d;
	logic               prev_blank_d;
	logic [SW-1:0]      skip_d;
	logic [FW-1:0]      inc_d;
	logic [TALLY_W:0]   sum_d;
	logic [TALLY_W-1:0] tally_d;

	assign adv_s1   = !item_s1.end_of_text || !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	always_comb begin
		logic [7:0] b;
		logic [7:0] b1;
		logic [7:0] bl;
		logic       v1;
		logic       vl;
		for (int k = 0; k < L; k++) begin
			if (FW'(k) < fill_q) begin
				ext[k] = win_q[k];
			end else if (FW'(k) == fill_q) begin
				ext[k] = item_s1.text_byte;
			end else begin
				ext[k] = 8'h00;
			end
		end
		ext_cnt = fill_q + FW'(1);
		if (item_s1.end_of_text) begin
			nret = ext_cnt;
		end else if (ext_cnt == FW'(L)) begin
			nret = FW'(1);
		end else begin
			nret = '0;
		end

		inside_d     = inside_q;
		prev_blank_d = prev_blank_q;
		skip_d       = skip_q;
		inc_d        = '0;
		for (int j = 0; j < L; j++) begin
			b  = ext[j];
			v1 = (j + 1 < L) && (int'(ext_cnt) > j + 1);
			b1 = ext[(j + 1) % L];
			vl = (j + L - 1 < L) && (int'(ext_cnt) > j + L - 1);
			bl = ext[(j + L - 1) % L];
			if (FW'(j) < nret) begin
				if (skip_d != '0) begin
					skip_d = skip_d - SW'(1);
				end else if (inside_d) begin
					if (b == mswc_pkg::CHAR_GT) begin
						inside_d = 1'b0;
					end
				end else if (b == mswc_pkg::CHAR_LT) begin
					inside_d = 1'b1;
				end else if (b == mswc_pkg::CHAR_AMP && v1 && b1 == mswc_pkg::CHAR_N
						&& vl && bl == mswc_pkg::CHAR_SEMI) begin
					skip_d = SW'(L - 1);
				end else if (mswc_pkg::is_blank(b)) begin
					prev_blank_d = 1'b1;
				end else begin
					if (prev_blank_d) begin
						inc_d = inc_d + FW'(1);
					end
					prev_blank_d = 1'b0;
				end
			end
		end

		sum_d   = {1'b0, tally_q} + (TALLY_W + 1)'(inc_d);
		tally_d = sum_d[TALLY_W] ? LIMIT : sum_d[TALLY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q     <= 1'b0;
			prev_blank_q <= 1'b1;
			tally_q      <= '0;
			skip_q       <= '0;
			fill_q       <= '0;
		end else if (valid_s1 && adv_s1) begin
			if (item_s1.end_of_text) begin
				inside_q     <= 1'b0;
				prev_blank_q <= 1'b1;
				tally_q      <= '0;
				skip_q       <= '0;
				fill_q       <= '0;
			end else begin
				inside_q     <= inside_d;
				prev_blank_q <= prev_blank_d;
				tally_q      <= tally_d;
				skip_q       <= skip_d;
				fill_q       <= (nret != '0) ? FW'(L - 1) : ext_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1 && !item_s1.end_of_text) begin
			for (int k = 0; k < L; k++) begin
				if (nret != '0) begin
					win_q[k] <= (k + 1 < L) ? ext[(k + 1) % L] : 8'h00;
				end else begin
					win_q[k] <= ext[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv_s1 && item_s1.end_of_text) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1 && item_s1.end_of_text) begin
			out_item_q.word_total      <= mswc_pkg::TOTAL_WIDTH'(tally_d);
			out_item_q.total_saturated <= (tally_d == LIMIT);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// a final byte leaves a fresh document behind
	`ASSERT_NEXT(a_reset_after_last, valid_s1 && adv_s1 && item_s1.end_of_text,
		fill_q == '0 && tally_q == '0 && skip_q == '0 && !inside_q,
		"state not cleared after final item")
	// entities are only recognized outside tags
	`ASSERT_NOW(a_skip_outside_tag, skip_q != '0, !inside_q,
		"entity skip active inside a tag")
	// saturation flag matches the reported count
	`ASSERT_NOW(a_sat_flag, out_valid_q,
		out_item_q.total_saturated == (out_item_q.word_total == mswc_pkg::TOTAL_WIDTH'(LIMIT)),
		"saturation flag disagrees with count")

endmodule
